FILE: src/slab_pkg.sv
package slab_pkg;

    localparam int DIV_STEPS = 29;
    localparam int QW        = 29;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_ZERO  = 2'd2;

    typedef enum logic [1:0] {
        FN_LOAD_SRC = 2'd0,
        FN_LOAD_DST = 2'd1,
        FN_READ     = 2'd2,
        FN_BLEND    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_IN_SPAN      = 3'd0,
        REG_OUT_SPAN     = 3'd1,
        REG_SCALE_OFFSET = 3'd2,
        REG_PLANE_MODE   = 3'd3,
        REG_X_SHIFT      = 3'd4,
        REG_Y_SHIFT      = 3'd5,
        REG_Z_SHIFT      = 3'd6,
        REG_A_SHIFT      = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        FIN_MEM,
        FIN_ZERO,
        FIN_RANGE,
        FIN_BLEND
    } t_fin;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MEM,
        ST_MEM_WAIT,
        ST_MUL,
        ST_DIV,
        ST_ADDR,
        ST_ACHK,
        ST_RD,
        ST_RD_WAIT,
        ST_CALC,
        ST_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] in_span;
        logic [15:0] out_span;
        logic [23:0] scale_offset;
        logic        plane_mode;
        logic [1:0]  x_shift;
        logic [1:0]  y_shift;
        logic [1:0]  z_shift;
        logic [1:0]  a_shift;
    } t_cfg;

    typedef struct packed {
        logic       take;
        logic       mem_op;
        logic       mul;
        logic       div_step;
        logic       addr_calc;
        logic       rd_issue;
        logic       calc;
        logic       wr;
        logic       finish;
        logic [1:0] plane;
        t_fin       fin;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  span_zero;
        logic  px_err;
        logic  addr_err;
        logic  out_free;
    } t_sts;

    // Planes in blend order; with one colour plane the middle two are skipped.
    function automatic logic [1:0] next_plane(input logic [1:0] p, input logic mode);
        logic [1:0] n;
        n = p + 2'd1;
        if (mode && p == 2'd0) begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

FILE: src/slab_ctrl.sv
module slab_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_plane_mode,
    input  slab_pkg::t_sts i_sts,
    output logic           o_ready,
    output slab_pkg::t_cmd o_cmd
);
    import slab_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_plane, n_plane;
    t_fin       r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_plane <= '0;
            r_fin   <= FIN_MEM;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_plane <= n_plane;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_plane = r_plane;
        n_fin   = r_fin;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.plane = r_plane;
        o_cmd.fin   = r_fin;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.func != FN_BLEND) begin
                    n_state = ST_MEM;
                end else if (i_sts.span_zero) begin
                    n_fin   = FIN_ZERO;
                    n_state = ST_DONE;
                end else if (i_sts.px_err) begin
                    n_fin   = FIN_RANGE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MEM: begin
                o_cmd.mem_op = 1'b1;
                n_state      = ST_MEM_WAIT;
            end
            ST_MEM_WAIT: begin
                n_fin   = FIN_MEM;
                n_state = ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = ST_ADDR;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                n_state         = ST_ACHK;
            end
            ST_ACHK: begin
                n_plane = 2'd0;
                if (i_sts.addr_err) begin
                    n_fin   = FIN_RANGE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                if (r_plane == 2'd3) begin
                    n_state = ST_RD_WAIT;
                end else begin
                    n_plane = next_plane(r_plane, i_plane_mode);
                end
            end
            ST_RD_WAIT: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_plane    = 2'd0;
                n_state    = ST_WR;
            end
            ST_WR: begin
                o_cmd.wr = 1'b1;
                if (r_plane == 2'd3) begin
                    n_fin   = FIN_BLEND;
                    n_state = ST_DONE;
                end else begin
                    n_plane = next_plane(r_plane, i_plane_mode);
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/slab_dp.sv
module slab_dp #(
    parameter int LINE_DEPTH = 4096,
    parameter int X_STEP     = 1,
    parameter int Y_STEP     = 1,
    parameter int Z_STEP     = 1,
    parameter int A_STEP     = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slab_pkg::t_cmd i_cmd,
    input  slab_pkg::t_cfg i_cfg,
    input  logic [1:0]     i_func,
    input  logic [1:0]     i_plane,
    input  logic [11:0]    i_address,
    input  logic [7:0]     i_value,
    input  logic [11:0]    i_pixel_x,
    input  logic           i_out_ready,
    output slab_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [7:0]     o_data_out,
    output logic [7:0]     o_alpha_out,
    output logic [1:0]     o_status
);
    import slab_pkg::*;

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int DEPTH = 4 * LINE_DEPTH;
    localparam int MW    = $clog2(DEPTH);
    localparam int STEPS [4] = '{X_STEP, Y_STEP, Z_STEP, A_STEP};

    logic [7:0] src_mem [0:DEPTH-1];
    logic [7:0] dst_mem [0:DEPTH-1];

    t_func       r_func;
    logic [1:0]  r_plane;
    logic [11:0] r_address;
    logic [7:0]  r_value;
    logic [11:0] r_px;
    logic [QW-1:0] r_quo;
    logic [15:0] r_rem;
    logic [AW-1:0] r_sadr [4];
    logic [AW-1:0] r_dadr [4];
    logic        r_addr_err;
    logic [7:0]  r_src_q, r_dst_q;
    logic        r_cap_valid;
    logic [1:0]  r_cap_plane;
    logic [7:0]  r_s [4];
    logic [7:0]  r_d [4];
    logic [7:0]  r_res [4];
    logic        r_out_valid;
    logic [7:0]  r_data_out, r_alpha_out;
    logic [1:0]  r_status;

    logic          w_addr_ok, w_px_ok;
    logic [MW-1:0] w_item_idx, w_src_ra, w_dst_ra, w_dst_wa;
    logic          w_src_we, w_dst_we;
    logic [7:0]    w_dst_wd;
    logic [27:0]   w_prod;
    logic [16:0]   w_trial;
    logic [16:0]   w_diff;
    logic [1:0]    w_sh [4];
    logic [31:0]   w_sa [4];
    logic [31:0]   w_da [4];
    logic          w_bad;
    logic [7:0]    w_inv;
    logic [15:0]   w_sum [3];
    logic [15:0]   w_dainv;

    assign w_addr_ok  = 32'(r_address) < 32'(LINE_DEPTH);
    assign w_px_ok    = 32'(r_px) < 32'(LINE_DEPTH);
    assign w_item_idx = MW'(r_plane) * MW'(LINE_DEPTH) + MW'(r_address);
    assign w_prod     = r_px * i_cfg.in_span;
    assign w_trial    = {r_rem, r_quo[QW-1]};
    assign w_diff     = w_trial - {1'b0, i_cfg.out_span};

    assign w_sh[0] = i_cfg.x_shift;
    assign w_sh[1] = i_cfg.y_shift;
    assign w_sh[2] = i_cfg.z_shift;
    assign w_sh[3] = i_cfg.a_shift;

    always_comb begin
        w_bad = 1'b0;
        for (int p = 0; p < 4; p++) begin
            w_sa[p] = (32'(r_quo) >> w_sh[p]) * 32'(STEPS[p]);
            w_da[p] = (32'(r_px) >> w_sh[p]) * 32'(STEPS[p]);
            if ((!i_cfg.plane_mode || p == 0 || p == 3) &&
                (w_sa[p] >= 32'(LINE_DEPTH) || w_da[p] >= 32'(LINE_DEPTH))) begin
                w_bad = 1'b1;
            end
        end
    end

    assign w_inv   = 8'd255 - r_s[3];
    assign w_dainv = 16'(r_d[3]) * 16'(w_inv);
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            w_sum[p] = 16'(r_s[p]) * 16'(r_s[3]) + 16'(r_d[p]) * 16'(w_inv);
        end
    end

    always_comb begin
        w_src_ra = w_item_idx;
        w_dst_ra = w_item_idx;
        if (i_cmd.rd_issue) begin
            w_src_ra = MW'(i_cmd.plane) * MW'(LINE_DEPTH) + MW'(r_sadr[i_cmd.plane]);
            w_dst_ra = MW'(i_cmd.plane) * MW'(LINE_DEPTH) + MW'(r_dadr[i_cmd.plane]);
        end
        w_src_we = i_cmd.mem_op && w_addr_ok && r_func == FN_LOAD_SRC;
        w_dst_we = 1'b0;
        w_dst_wa = w_item_idx;
        w_dst_wd = r_value;
        if (i_cmd.wr) begin
            w_dst_we = 1'b1;
            w_dst_wa = MW'(i_cmd.plane) * MW'(LINE_DEPTH) + MW'(r_dadr[i_cmd.plane]);
            w_dst_wd = r_res[i_cmd.plane];
        end else if (i_cmd.mem_op && w_addr_ok && r_func == FN_LOAD_DST) begin
            w_dst_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_src_we) begin
            src_mem[w_item_idx] <= r_value;
        end
        r_src_q <= src_mem[w_src_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_dst_we) begin
            dst_mem[w_dst_wa] <= w_dst_wd;
        end
        r_dst_q <= dst_mem[w_dst_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func    <= t_func'(i_func);
            r_plane   <= i_plane;
            r_address <= i_address;
            r_value   <= i_value;
            r_px      <= i_pixel_x;
        end
        if (i_cmd.mul) begin
            r_quo <= QW'(w_prod) + QW'(i_cfg.scale_offset);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_diff[16]) begin
                r_rem <= w_diff[15:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[15:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.addr_calc) begin
            r_addr_err <= w_bad;
            for (int p = 0; p < 4; p++) begin
                r_sadr[p] <= w_sa[p][AW-1:0];
                r_dadr[p] <= w_da[p][AW-1:0];
            end
        end
        if (r_cap_valid) begin
            r_s[r_cap_plane] <= r_src_q;
            r_d[r_cap_plane] <= r_dst_q;
        end
        r_cap_plane <= i_cmd.plane;
        if (i_cmd.calc) begin
            for (int p = 0; p < 3; p++) begin
                r_res[p] <= w_sum[p][15:8];
            end
            r_res[3] <= r_s[3] + w_dainv[15:8];
        end
        if (i_cmd.finish) begin
            case (i_cmd.fin)
                FIN_MEM: begin
                    r_alpha_out <= '0;
                    if (!w_addr_ok) begin
                        r_data_out <= '0;
                        r_status   <= STS_RANGE;
                    end else begin
                        r_data_out <= (r_func == FN_READ) ? r_dst_q : 8'd0;
                        r_status   <= STS_OK;
                    end
                end
                FIN_ZERO: begin
                    r_data_out  <= '0;
                    r_alpha_out <= '0;
                    r_status    <= STS_ZERO;
                end
                FIN_RANGE: begin
                    r_data_out  <= '0;
                    r_alpha_out <= '0;
                    r_status    <= STS_RANGE;
                end
                FIN_BLEND: begin
                    r_data_out  <= r_res[0];
                    r_alpha_out <= r_res[3];
                    r_status    <= STS_OK;
                end
                default: begin
                    r_data_out  <= '0;
                    r_alpha_out <= '0;
                    r_status    <= STS_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_valid <= i_cmd.rd_issue;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.span_zero = i_cfg.out_span == 16'd0;
    assign o_sts.px_err    = !w_px_ok;
    assign o_sts.addr_err  = r_addr_err;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_alpha_out = r_alpha_out;
    assign o_status    = r_status;

endmodule

FILE: src/scaled_line_alpha_blend.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser: func[1:0]; tdata: plane, address, value, pixel_x
// m_axis    out        tuser: status[1:0]; tdata: data_out, alpha_out
// apb       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A load or read passes through the check and memory states to a result beat.
// A blend runs a multiply, a restoring divide and an address check, then reads and writes each used plane
// through the single read and write port of each store; a zero span or a range error ends it early.
// Reset clears only control state; the line stores hold garbage until loaded.
// A result beat waits in an output register; the next beat is taken once the
// block is back in idle, even while that result stalls.
module scaled_line_alpha_blend #(
    parameter int LINE_DEPTH = 4096,
    parameter int X_STEP     = 1,
    parameter int Y_STEP     = 1,
    parameter int Z_STEP     = 1,
    parameter int A_STEP     = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // plane[1:0], address[13:2], value[21:14], pixel_x[33:22]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // data_out[7:0], alpha_out[15:8]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slab_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{in_span: 16'd1, out_span: 16'd1, default: '0};
        end else if (w_wr) begin
            case (t_reg'(paddr[4:2]))
                REG_IN_SPAN:      r_cfg.in_span      <= pwdata[15:0];
                REG_OUT_SPAN:     r_cfg.out_span     <= pwdata[15:0];
                REG_SCALE_OFFSET: r_cfg.scale_offset <= pwdata[23:0];
                REG_PLANE_MODE:   r_cfg.plane_mode   <= pwdata[0];
                REG_X_SHIFT:      r_cfg.x_shift      <= pwdata[1:0];
                REG_Y_SHIFT:      r_cfg.y_shift      <= pwdata[1:0];
                REG_Z_SHIFT:      r_cfg.z_shift      <= pwdata[1:0];
                REG_A_SHIFT:      r_cfg.a_shift      <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_IN_SPAN:      prdata = 32'(r_cfg.in_span);
            REG_OUT_SPAN:     prdata = 32'(r_cfg.out_span);
            REG_SCALE_OFFSET: prdata = 32'(r_cfg.scale_offset);
            REG_PLANE_MODE:   prdata = 32'(r_cfg.plane_mode);
            REG_X_SHIFT:      prdata = 32'(r_cfg.x_shift);
            REG_Y_SHIFT:      prdata = 32'(r_cfg.y_shift);
            REG_Z_SHIFT:      prdata = 32'(r_cfg.z_shift);
            REG_A_SHIFT:      prdata = 32'(r_cfg.a_shift);
            default:          prdata = '0;
        endcase
    end

    slab_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_plane_mode (r_cfg.plane_mode),
        .i_sts        (w_sts),
        .o_ready      (s_axis_tready),
        .o_cmd        (w_cmd)
    );

    slab_dp #(
        .LINE_DEPTH (LINE_DEPTH),
        .X_STEP     (X_STEP),
        .Y_STEP     (Y_STEP),
        .Z_STEP     (Z_STEP),
        .A_STEP     (A_STEP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_func      (s_axis_tuser),
        .i_plane     (s_axis_tdata[1:0]),
        .i_address   (s_axis_tdata[13:2]),
        .i_value     (s_axis_tdata[21:14]),
        .i_pixel_x   (s_axis_tdata[33:22]),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_data_out  (m_axis_tdata[7:0]),
        .o_alpha_out (m_axis_tdata[15:8]),
        .o_status    (m_axis_tuser)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == STS_OK || m_axis_tuser == STS_RANGE ||
                          m_axis_tuser == STS_ZERO)
        else $error("undefined status on result beat");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STS_OK |-> m_axis_tdata == 16'd0)
        else $error("error beat carries data");

    a_blend_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr |-> !w_sts.addr_err)
        else $error("destination written after a range error");

endmodule

FILE: dv/scaled_line_alpha_blend_tb.sv
module scaled_line_alpha_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slab_pkg::*;

    localparam int DEPTH = 4096;
    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        t_func      func;
        logic [1:0] plane;
        logic [11:0] address;
        logic [7:0] value;
        logic [11:0] pixel_x;
    } t_beat;

    typedef struct {
        logic [7:0] data_out;
        logic [7:0] alpha_out;
        logic [1:0] status;
    } t_blend_res;

    typedef struct {
        t_beat      b;
        bit         typed;
        t_blend_res want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    scaled_line_alpha_blend u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mirror of the block's line stores and registers.
    logic [7:0] src_line [4*DEPTH];
    logic [7:0] dst_line [4*DEPTH];
    bit         src_known [4*DEPTH];
    bit         dst_known [4*DEPTH];
    t_cfg       cfg;

    t_blend_res pending_q[$];
    int         errors = 0;
    int         beats_sent = 0;
    int         burst_left = 0;
    bit         hold_off = 1'b0;
    bit         rx_steady = 1'b0;
    int         idle_cycles = 0;
    int         rx_cycle = 0;

    function automatic logic [1:0] plane_shift(input int p);
        case (p)
            0: return cfg.x_shift;
            1: return cfg.y_shift;
            2: return cfg.z_shift;
            default: return cfg.a_shift;
        endcase
    endfunction

    function automatic bit plane_used(input int p);
        return !(cfg.plane_mode && (p == 1 || p == 2));
    endfunction

    // Source and destination addresses of every blended plane; 0 if any is out of range.
    function automatic bit blend_addrs(input logic [11:0] px, output int sa[4], output int da[4]);
        longint unsigned xs;
        xs = (longint'(px) * cfg.in_span + cfg.scale_offset) / cfg.out_span;
        for (int p = 0; p < 4; p++) begin
            sa[p] = 0;
            da[p] = 0;
            if (plane_used(p)) begin
                if ((xs >> plane_shift(p)) >= DEPTH) return 0;
                sa[p] = int'(xs >> plane_shift(p));
                da[p] = int'(px >> plane_shift(p));
            end
        end
        return 1;
    endfunction

    // Finds a byte the beat would read that was never written.
    function automatic bit find_unwritten(input t_beat b, output logic [1:0] pl,
                                          output logic [11:0] ad, output bit in_dst);
        int sa[4];
        int da[4];
        if (b.func == FN_READ) begin
            pl = b.plane;
            ad = b.address;
            in_dst = 1'b1;
            return !dst_known[b.plane*DEPTH + b.address];
        end
        if (b.func != FN_BLEND || cfg.out_span == 0 || !blend_addrs(b.pixel_x, sa, da))
            return 0;
        for (int p = 0; p < 4; p++) begin
            if (plane_used(p)) begin
                pl = 2'(p);
                if (!src_known[p*DEPTH + sa[p]]) begin
                    ad = 12'(sa[p]);
                    in_dst = 1'b0;
                    return 1;
                end
                if (!dst_known[p*DEPTH + da[p]]) begin
                    ad = 12'(da[p]);
                    in_dst = 1'b1;
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic t_blend_res predict_beat(input t_beat b);
        t_blend_res r;
        int sa[4];
        int da[4];
        int idx;
        logic [7:0] alpha;
        logic [7:0] inv;
        logic [7:0] res[4];
        r = '{8'd0, 8'd0, STS_OK};
        idx = b.plane*DEPTH + b.address;
        case (b.func)
            FN_LOAD_SRC: begin
                src_line[idx] = b.value;
                src_known[idx] = 1'b1;
            end
            FN_LOAD_DST: begin
                dst_line[idx] = b.value;
                dst_known[idx] = 1'b1;
            end
            FN_READ: r.data_out = dst_line[idx];
            default: begin
                if (cfg.out_span == 0) begin
                    r.status = STS_ZERO;
                end else if (!blend_addrs(b.pixel_x, sa, da)) begin
                    r.status = STS_RANGE;
                end else begin
                    alpha = src_line[3*DEPTH + sa[3]];
                    inv = 8'd255 - alpha;
                    for (int p = 0; p < 3; p++) begin
                        if (plane_used(p))
                            res[p] = 8'((16'(src_line[p*DEPTH + sa[p]]) * alpha
                                       + 16'(dst_line[p*DEPTH + da[p]]) * inv) >> 8);
                    end
                    res[3] = alpha + 8'((16'(dst_line[3*DEPTH + da[3]]) * inv) >> 8);
                    for (int p = 0; p < 4; p++) begin
                        if (plane_used(p)) dst_line[p*DEPTH + da[p]] = res[p];
                    end
                    r.data_out = res[0];
                    r.alpha_out = res[3];
                end
            end
        endcase
        return r;
    endfunction

    task automatic drive_beat(input t_beat b, input bit typed, input t_blend_res want);
        t_blend_res r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        r = predict_beat(b);
        pending_q.push_back(typed ? want : r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, b.pixel_x, b.value, b.address, b.plane};
        s_axis_tuser <= b.func;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // Fills any unwritten byte the beat would read before sending it.
    task automatic send_beat(input t_beat b, input bit typed = 0,
                             input t_blend_res want = '{8'd0, 8'd0, STS_OK});
        t_beat fill;
        logic [1:0] pl;
        logic [11:0] ad;
        bit in_dst;
        while (find_unwritten(b, pl, ad, in_dst)) begin
            fill = '{t_func'(in_dst ? FN_LOAD_DST : FN_LOAD_SRC), pl, ad, 8'($urandom),
                     12'($urandom)};
            drive_beat(fill, 0, '{8'd0, 8'd0, STS_OK});
        end
        drive_beat(b, typed, want);
    endtask

    task automatic write_reg(input t_reg r, input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (60) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(r) << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_IN_SPAN: cfg.in_span = v[15:0];
            REG_OUT_SPAN: cfg.out_span = v[15:0];
            REG_SCALE_OFFSET: cfg.scale_offset = v[23:0];
            REG_PLANE_MODE: cfg.plane_mode = v[0];
            REG_X_SHIFT: cfg.x_shift = v[1:0];
            REG_Y_SHIFT: cfg.y_shift = v[1:0];
            REG_Z_SHIFT: cfg.z_shift = v[1:0];
            default: cfg.a_shift = v[1:0];
        endcase
    endtask

    task automatic write_all(input logic [15:0] ins, input logic [15:0] outs,
                             input logic [23:0] offs, input logic mode,
                             input logic [1:0] xs, input logic [1:0] ys,
                             input logic [1:0] zs, input logic [1:0] as);
        write_reg(REG_IN_SPAN, {16'($urandom_range(0, 65535)), ins});
        write_reg(REG_OUT_SPAN, {16'd0, outs});
        write_reg(REG_SCALE_OFFSET, {8'hA5, offs});
        write_reg(REG_PLANE_MODE, {31'd0, mode});
        write_reg(REG_X_SHIFT, {30'd0, xs});
        write_reg(REG_Y_SHIFT, {30'd0, ys});
        write_reg(REG_Z_SHIFT, {30'd0, zs});
        write_reg(REG_A_SHIFT, {30'h3FFFFFFF, as});
    endtask

    function automatic t_beat random_beat();
        t_beat b;
        int pick;
        pick = $urandom_range(0, 99);
        b.func = t_func'(pick < 25 ? FN_LOAD_SRC : pick < 50 ? FN_LOAD_DST :
                         pick < 65 ? FN_READ : FN_BLEND);
        b.plane = 2'($urandom);
        b.address = ($urandom_range(0, 15) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
        b.value = 8'($urandom);
        b.pixel_x = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
        return b;
    endfunction

    t_row directed_rows[] = '{
        '{'{FN_LOAD_SRC, 2'd0, 12'd0, 8'd0, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd1, 12'd0, 8'd255, 12'd4095}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd2, 12'd0, 8'd128, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd3, 12'd0, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd0, 12'd0, 8'd200, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd1, 12'd0, 8'd1, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd2, 12'd0, 8'd77, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd3, 12'd0, 8'd0, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_READ, 2'd0, 12'd0, 8'd0, 12'd0}, 1, '{8'd200, 8'd0, STS_OK}},
        '{'{FN_BLEND, 2'd0, 12'd0, 8'd0, 12'd0}, 1, '{8'd0, 8'd255, STS_OK}},
        '{'{FN_READ, 2'd3, 12'd0, 8'd0, 12'd0}, 1, '{8'd255, 8'd0, STS_OK}},
        '{'{FN_READ, 2'd2, 12'd0, 8'd0, 12'd0}, 0, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd0, 12'd4095, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd1, 12'd4095, 8'd0, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd2, 12'd4095, 8'd0, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_SRC, 2'd3, 12'd4095, 8'd0, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd0, 12'd4095, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd1, 12'd4095, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd2, 12'd4095, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_LOAD_DST, 2'd3, 12'd4095, 8'd255, 12'd0}, 1, '{8'd0, 8'd0, STS_OK}},
        '{'{FN_BLEND, 2'd3, 12'd4095, 8'd255, 12'd4095}, 1, '{8'd254, 8'd254, STS_OK}},
        '{'{FN_READ, 2'd2, 12'd4095, 8'd0, 12'd0}, 1, '{8'd254, 8'd0, STS_OK}},
        '{'{FN_READ, 2'd1, 12'd4095, 8'd0, 12'd0}, 0, '{8'd0, 8'd0, STS_OK}}
    };

    initial begin
        int phase;
        cfg = '{16'd1, 16'd1, 24'd0, 1'b0, 2'd0, 2'd0, 2'd0, 2'd0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) send_beat(directed_rows[i].b, directed_rows[i].typed,
                                             directed_rows[i].want);
        write_reg(REG_OUT_SPAN, 32'd0);
        send_beat('{FN_BLEND, 2'd0, 12'd0, 8'd0, 12'd5}, 1, '{8'd0, 8'd0, STS_ZERO});
        write_all(16'd65535, 16'd1, 24'd0, 1'b0, 2'd0, 2'd0, 2'd0, 2'd0);
        send_beat('{FN_BLEND, 2'd0, 12'd0, 8'd0, 12'd1}, 1, '{8'd0, 8'd0, STS_RANGE});

        phase = 0;
        while (beats_sent < RANDOM_ITEMS - 150) begin
            case (phase % 6)
                0: write_all(16'd1, 16'd1, 24'd0, 1'b0, 2'd0, 2'd0, 2'd0, 2'd0);
                1: write_all(16'd0, 16'd65535, 24'hFFFFFF, 1'b1, 2'd3, 2'd3, 2'd3, 2'd3);
                2: write_all(16'd65535, 16'd65535, 24'd0, 1'b0, 2'd1, 2'd2, 2'd3, 2'd0);
                default: write_all(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                                   24'($urandom_range(0, 7)), 1'($urandom),
                                   2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
            endcase
            repeat ($urandom_range(120, 220)) send_beat(random_beat());
            phase++;
        end

        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("scaled_line_alpha_blend_tb: clean");
        end else begin
            $display("scaled_line_alpha_blend_tb: errors");
        end
        $finish;
    end

    initial begin
        wait (beats_sent > 500);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_blend_res want;
        rx_cycle++;
        if (rx_cycle % 500 == 0) rx_steady = $urandom_range(0, 2) == 0;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h/%h", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata !== {want.alpha_out, want.data_out}
                        || m_axis_tuser !== want.status) begin
                    $display("%0t: expected data %h alpha %h status %0d, got %h %h %0d",
                             $time, want.data_out, want.alpha_out, want.status,
                             m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser);
                    errors++;
                end
            end
        end
        if (i_rst_n && !(m_axis_tvalid && m_axis_tready) && !(s_axis_tvalid && s_axis_tready)
                && !psel) begin
            idle_cycles++;
        end else begin
            idle_cycles = 0;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("scaled_line_alpha_blend_tb: errors");
            $finish;
        end
        m_axis_tready <= !hold_off && (rx_steady || (rx_cycle % 9) < 5
                         || $urandom_range(0, 1) == 0);
    end

endmodule
